### src/dlc_pkg.sv
package dlc_pkg;

   // Item opcodes.
   localparam logic [1:0] OP_SLOT    = 2'd0;
   localparam logic [1:0] OP_JUMP1   = 2'd1;
   localparam logic [1:0] OP_JUMP2   = 2'd2;
   localparam logic [1:0] OP_CONTROL = 2'd3;

   // Configuration register indexes.
   localparam logic [1:0] CSR_FIRST_LOC  = 2'd0;
   localparam logic [1:0] CSR_SECOND_LOC = 2'd1;
   localparam logic [1:0] CSR_DANGER     = 2'd2;

   localparam logic [20:0] ADDR_MASK       = 21'h1FFFFE;
   localparam logic [8:0]  DANGER_LIMIT    = 9'h080;
   localparam logic [8:0]  REG_DMA_CONTROL = 9'h096;
   localparam int          DMA_MASTER_BIT  = 9;
   localparam int          DMA_COPPER_BIT  = 7;
   localparam int          SET_BIT         = 15;

   typedef struct packed {
      logic [1:0]  op;
      logic [15:0] first_word;
      logic [15:0] second_word;
      logic [8:0]  scan_line;
      logic [7:0]  beam_clock;
      logic        blitter_busy;
      logic [15:0] control_value;
   } item_type;

   typedef struct packed {
      logic        write_valid;
      logic [8:0]  write_register;
      logic [15:0] write_value;
      logic [20:0] fetch_address;
      logic        copper_active;
      logic [10:0] dma_control;
   } result_type;

   typedef struct packed {
      logic [20:0] list_address;
      logic        running;
      logic [10:0] dma_bits;
   } state_type;

   typedef struct packed {
      logic [20:0] first_list_location;
      logic [20:0] second_list_location;
      logic        danger_enable;
   } cfg_type;

endpackage

### src/dlc_req_if.sv
interface dlc_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  op;
   logic [15:0] first_word;
   logic [15:0] second_word;
   logic [8:0]  scan_line;
   logic [7:0]  beam_clock;
   logic        blitter_busy;
   logic [15:0] control_value;

   modport source (output valid, op, first_word, second_word, scan_line, beam_clock,
                   blitter_busy, control_value, input ready);
   modport sink (input valid, op, first_word, second_word, scan_line, beam_clock,
                 blitter_busy, control_value, output ready);
endinterface

### src/dlc_rsp_if.sv
interface dlc_rsp_if;
   logic        valid;
   logic        ready;
   logic        write_valid;
   logic [8:0]  write_register;
   logic [15:0] write_value;
   logic [20:0] fetch_address;
   logic        copper_active;
   logic [10:0] dma_control;

   modport source (output valid, write_valid, write_register, write_value, fetch_address,
                   copper_active, dma_control, input ready);
   modport sink (input valid, write_valid, write_register, write_value, fetch_address,
                 copper_active, dma_control, output ready);
endinterface

### src/dlc_csr.sv
module dlc_csr (
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [3:0]        paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready,
   output dlc_pkg::cfg_type  cfg
);

   logic [20:0] first_loc_ff;
   logic [20:0] second_loc_ff;
   logic        danger_ff;
   logic        wr_en;
   logic [1:0]  index;

   assign pready = 1'b1;
   assign wr_en  = psel & penable & pwrite;
   assign index  = paddr[3:2];

   // Register writes complete in the access phase.
   always_ff @(posedge clock) begin
      if (reset) begin
         first_loc_ff  <= '0;
         second_loc_ff <= '0;
         danger_ff     <= 1'b0;
      end else if (wr_en) begin
         case (index)
            dlc_pkg::CSR_FIRST_LOC:  first_loc_ff  <= pwdata[20:0];
            dlc_pkg::CSR_SECOND_LOC: second_loc_ff <= pwdata[20:0];
            dlc_pkg::CSR_DANGER:     danger_ff     <= pwdata[0];
            default: ;
         endcase
      end
   end

   // Read back.
   always_comb begin
      case (index)
         dlc_pkg::CSR_FIRST_LOC:  prdata = {11'd0, first_loc_ff};
         dlc_pkg::CSR_SECOND_LOC: prdata = {11'd0, second_loc_ff};
         dlc_pkg::CSR_DANGER:     prdata = {31'd0, danger_ff};
         default:                 prdata = '0;
      endcase
   end

   assign cfg.first_list_location  = first_loc_ff;
   assign cfg.second_list_location = second_loc_ff;
   assign cfg.danger_enable        = danger_ff;

endmodule

### src/dlc_exec.sv
module dlc_exec (
   input  dlc_pkg::item_type   item,
   input  dlc_pkg::state_type  state,
   input  dlc_pkg::cfg_type    cfg,
   output dlc_pkg::state_type  state_next,
   output dlc_pkg::result_type result
);

   logic [20:0] first_addr;
   logic [20:0] second_addr;
   logic        dma_on;
   logic        is_move;
   logic [8:0]  move_reg;
   logic        move_pass;
   logic [15:0] ctrl_word;
   logic        ctrl_apply;
   logic [10:0] ctrl_dma;
   logic        ctrl_on;
   logic [20:0] ctrl_addr;
   logic        ctrl_running;
   logic [7:0]  vmask;
   logic [6:0]  hmask;
   logic [7:0]  vbeam;
   logic [7:0]  vtarget;
   logic [6:0]  hbeam;
   logic [6:0]  htarget;
   logic        past;
   logic        skip;
   logic [20:0] addr_plus4;
   logic [20:0] addr_plus8;

   assign first_addr  = cfg.first_list_location & dlc_pkg::ADDR_MASK;
   assign second_addr = cfg.second_list_location & dlc_pkg::ADDR_MASK;
   assign dma_on      = state.dma_bits[dlc_pkg::DMA_MASTER_BIT]
                      & state.dma_bits[dlc_pkg::DMA_COPPER_BIT];

   // MOVE decode and the danger filter.
   assign is_move   = ~item.first_word[0];
   assign move_reg  = {item.first_word[8:1], 1'b0};
   assign move_pass = ~((move_reg < dlc_pkg::DANGER_LIMIT) & ~cfg.danger_enable);

   // A DMA control write comes from the processor or from a MOVE to its offset.
   assign ctrl_word  = (item.op == dlc_pkg::OP_CONTROL) ? item.control_value
                                                        : item.second_word;
   assign ctrl_apply = (item.op == dlc_pkg::OP_CONTROL)
                     | (state.running & dma_on & is_move & move_pass
                        & (move_reg == dlc_pkg::REG_DMA_CONTROL));

   always_comb begin
      if (ctrl_word[dlc_pkg::SET_BIT]) begin
         ctrl_dma = state.dma_bits | ctrl_word[10:0];
      end else begin
         ctrl_dma = state.dma_bits & ~ctrl_word[10:0];
      end
      ctrl_on = ctrl_dma[dlc_pkg::DMA_MASTER_BIT] & ctrl_dma[dlc_pkg::DMA_COPPER_BIT];
      ctrl_addr    = state.list_address;
      ctrl_running = state.running;
      if (ctrl_on && !state.running) begin
         ctrl_addr    = first_addr;
         ctrl_running = 1'b1;
      end else if (!ctrl_on) begin
         ctrl_running = 1'b0;
      end
   end

   // Masked beam compare for WAIT and SKIP; the vertical mask top bit is forced.
   assign vmask   = {1'b1, item.second_word[14:8]};
   assign hmask   = item.second_word[7:1];
   assign vbeam   = item.scan_line[7:0] & vmask;
   assign vtarget = item.first_word[15:8] & vmask;
   assign hbeam   = item.beam_clock[6:0] & hmask;
   assign htarget = item.first_word[7:1] & hmask;
   assign past    = (vbeam > vtarget || (vbeam == vtarget && hbeam >= htarget))
                  && (item.second_word[dlc_pkg::SET_BIT] || !item.blitter_busy);
   assign skip    = item.second_word[0];

   assign addr_plus4 = (state.list_address + 21'd4) & dlc_pkg::ADDR_MASK;
   assign addr_plus8 = (state.list_address + 21'd8) & dlc_pkg::ADDR_MASK;

   // Next state and the emitted register write.
   always_comb begin
      state_next            = state;
      result.write_valid    = 1'b0;
      result.write_register = '0;
      result.write_value    = '0;
      case (item.op)
         dlc_pkg::OP_SLOT: begin
            if (!(state.running && dma_on)) begin
               state_next.running = 1'b0;
            end else if (is_move) begin
               if (move_pass) begin
                  result.write_valid    = 1'b1;
                  result.write_register = move_reg;
                  result.write_value    = item.second_word;
               end
               if (ctrl_apply) begin
                  state_next.dma_bits     = ctrl_dma;
                  state_next.running      = ctrl_running;
                  state_next.list_address = (ctrl_addr + 21'd4) & dlc_pkg::ADDR_MASK;
               end else begin
                  state_next.list_address = addr_plus4;
               end
            end else if (skip) begin
               state_next.list_address = past ? addr_plus8 : addr_plus4;
            end else if (past) begin
               state_next.list_address = addr_plus4;
            end
         end
         dlc_pkg::OP_JUMP1: begin
            state_next.list_address = first_addr;
            state_next.running      = dma_on;
         end
         dlc_pkg::OP_JUMP2: begin
            state_next.list_address = second_addr;
            state_next.running      = dma_on;
         end
         default: begin
            state_next.dma_bits     = ctrl_dma;
            state_next.running      = ctrl_running;
            state_next.list_address = ctrl_addr;
         end
      endcase
      result.fetch_address = state_next.list_address;
      result.copper_active = state_next.running;
      result.dma_control   = state_next.dma_bits;
   end

endmodule

### src/display_list_coprocessor.sv
// Display list coprocessor. Each request transfer carries one event (copper slot, jump to
// list one or two, or a processor DMA control write) and produces exactly one response.
// The block takes one request per clock while req.ready is high: the event is decoded and
// applied to the list address, running flag and DMA control bits combinationally, and the
// response is registered in a two-entry output buffer (output register plus skid register)
// that lets requests keep flowing while a response waits to be taken; req.ready drops only
// when both entries are full. Configuration registers are written through the APB port and
// should be changed only while no responses are outstanding.
module display_list_coprocessor (
   input  logic        clock,
   input  logic        reset,
   dlc_req_if.sink     req_bus,
   dlc_rsp_if.source   rsp_bus,
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [3:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   dlc_pkg::cfg_type    cfg;
   dlc_pkg::item_type   item;
   dlc_pkg::state_type  state_ff;
   dlc_pkg::state_type  state_in;
   dlc_pkg::result_type result;
   dlc_pkg::result_type out_ff;
   dlc_pkg::result_type skid_ff;
   logic                out_valid_ff;
   logic                skid_valid_ff;
   logic                accept;
   logic                take;

   dlc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   assign item.op            = req_bus.op;
   assign item.first_word    = req_bus.first_word;
   assign item.second_word   = req_bus.second_word;
   assign item.scan_line     = req_bus.scan_line;
   assign item.beam_clock    = req_bus.beam_clock;
   assign item.blitter_busy  = req_bus.blitter_busy;
   assign item.control_value = req_bus.control_value;

   dlc_exec u_exec (
      .item       (item),
      .state      (state_ff),
      .cfg        (cfg),
      .state_next (state_in),
      .result     (result)
   );

   assign req_bus.ready = ~skid_valid_ff;
   assign accept        = req_bus.valid & ~skid_valid_ff;
   assign take          = out_valid_ff & rsp_bus.ready;

   // Architectural state advances on every request transfer.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (accept) begin
         state_ff <= state_in;
      end
   end

   // Output register with a skid entry behind it.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (take) begin
            out_ff        <= skid_ff;
            skid_valid_ff <= 1'b0;
         end
      end else if (accept) begin
         if (out_valid_ff && !take) begin
            skid_ff       <= result;
            skid_valid_ff <= 1'b1;
         end else begin
            out_ff       <= result;
            out_valid_ff <= 1'b1;
         end
      end else if (take) begin
         out_valid_ff <= 1'b0;
      end
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.write_valid    = out_ff.write_valid;
   assign rsp_bus.write_register = out_ff.write_register;
   assign rsp_bus.write_value    = out_ff.write_value;
   assign rsp_bus.fetch_address  = out_ff.fetch_address;
   assign rsp_bus.copper_active  = out_ff.copper_active;
   assign rsp_bus.dma_control    = out_ff.dma_control;

   // The skid entry is only occupied behind a full output register.
   assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry holds a response while the output register is empty");

   // The copper can only be running while master and copper DMA are both enabled.
   assert property (@(posedge clock) disable iff (reset)
      state_ff.running |-> (state_ff.dma_bits[dlc_pkg::DMA_MASTER_BIT]
                            && state_ff.dma_bits[dlc_pkg::DMA_COPPER_BIT]))
      else $error("copper running with its DMA disabled");

   // The list address stays even.
   assert property (@(posedge clock) disable iff (reset)
      !state_ff.list_address[0])
      else $error("list address became odd");

   // A response without a register write carries zero write fields.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_bus.valid && !rsp_bus.write_valid) |->
         (rsp_bus.write_register == 9'd0 && rsp_bus.write_value == 16'd0))
      else $error("write fields not cleared on a response without a write");

endmodule
